>>> rtl/core/frustum_cull_classifier_top_macros.svh
// Assertion macros used by the frustum cull classifier back end (fcc_back).
// Expects clk and rst_n in the scope of each use.
`ifndef FRUSTUM_CULL_CLASSIFIER_TOP_MACROS_SVH
`define FRUSTUM_CULL_CLASSIFIER_TOP_MACROS_SVH

// Same-cycle implication.
`define FCC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FCC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/fcc_pkg.sv
// Shared types and constants for the frustum cull classifier.
// No dependencies; imported by every module of the block except fcc_fifo.
`default_nettype none

package fcc_pkg;

    localparam int NUM_PLANES_DEF = 6;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int COEF_W     = 32;
    localparam int IDX_W      = 3;
    localparam int OP_W       = 2;
    localparam int RADIUS_W   = 31;
    localparam int VERDICT_W  = 2;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam int LANES  = 4;
    localparam int MUL_W  = COEF_W + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam int DIST_W = 2 * COEF_W + 3;

    localparam int CMD_Q_DEPTH = 2;
    localparam int RES_Q_DEPTH = 2;

    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_POINT  = 2'd1;
    localparam logic [OP_W-1:0] OP_SPHERE = 2'd2;

    localparam logic [VERDICT_W-1:0] VERDICT_INSIDE    = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_OUTSIDE   = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_INTERSECT = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] REG_EYE_X = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_EYE_Y = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_EYE_Z = 2'd2;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_POINT,
        CMD_SPHERE
    } cmd_kind_t;

    typedef struct packed {
        logic [OP_W-1:0]          operation;
        logic [IDX_W-1:0]         plane_index;
        logic signed [COEF_W-1:0] coeff_a;
        logic signed [COEF_W-1:0] coeff_b;
        logic signed [COEF_W-1:0] coeff_c;
        logic signed [COEF_W-1:0] coeff_d;
        logic signed [COEF_W-1:0] pos_x;
        logic signed [COEF_W-1:0] pos_y;
        logic signed [COEF_W-1:0] pos_z;
        logic [RADIUS_W-1:0]      radius;
    } in_t;

    typedef struct packed {
        logic [VERDICT_W-1:0] verdict;
        logic [IDX_W-1:0]     culling_plane;
        logic                 culled;
    } res_t;

    // Loads carry a, b, c, d in w0..w3; tests carry x, y, z, radius.
    typedef struct packed {
        cmd_kind_t                kind;
        logic [IDX_W-1:0]         idx;
        logic signed [COEF_W-1:0] w0;
        logic signed [COEF_W-1:0] w1;
        logic signed [COEF_W-1:0] w2;
        logic signed [COEF_W-1:0] w3;
    } cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/frustum_cull_classifier_top.sv
// Frustum cull classifier: point and sphere tests against NUM_PLANES stored planes,
// signed fixed point with FRAC_BITS fraction bits. A load is stored as the back end pops
// it; a point runs a multiply, sum and compare step per plane and a sphere first checks
// whether the eye lies within it (then inside at once), each up to a cull or all NUM_PLANES
// planes. The back-end sequencer runs one plane at a time through four shared
// 33x33 multipliers. A two-entry command queue and a two-entry result queue let
// input and output stall independently. Uses fcc_pkg, fcc_front, fcc_fifo, fcc_back.
`default_nettype none

module frustum_cull_classifier_top #(
    parameter int NUM_PLANES = fcc_pkg::NUM_PLANES_DEF,
    parameter int FRAC_BITS  = fcc_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  fcc_pkg::in_t                   item,
    output logic                           empty,
    input  logic                           pop,
    output fcc_pkg::res_t                  result,
    input  logic                           cfg_write,
    input  logic [fcc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [fcc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    import fcc_pkg::*;

    logic q_push;
    cmd_t q_cmd;
    logic q_full;
    logic q_empty;
    cmd_t cmd_head;
    logic cmd_pop;
    logic res_full;
    logic res_push;
    res_t res_data;

    fcc_front #(
        .NUM_PLANES (NUM_PLANES)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .item   (item),
        .full   (full),
        .q_push (q_push),
        .q_cmd  (q_cmd),
        .q_full (q_full)
    );

    fcc_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_Q_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_push),
        .wdata (q_cmd),
        .full  (q_full),
        .rd    (cmd_pop),
        .rdata (cmd_head),
        .empty (q_empty)
    );

    fcc_back #(
        .NUM_PLANES (NUM_PLANES),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd_valid (!q_empty),
        .cmd       (cmd_head),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_data)
    );

    fcc_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (RES_Q_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (res_push),
        .wdata (res_data),
        .full  (res_full),
        .rd    (pop),
        .rdata (result),
        .empty (empty)
    );

endmodule

`default_nettype wire

>>> rtl/core/fcc_fifo.sv
// Small synchronous FIFO used for the command and result queues.
// Standalone; width and depth set by the instantiating module.
`default_nettype none

module fcc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             rd,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rdata = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/fcc_front.sv
// Front end: accepts input transactions, decodes and filters them into commands.
// Depends on fcc_pkg; feeds the command queue.
`default_nettype none

module fcc_front #(
    parameter int NUM_PLANES = fcc_pkg::NUM_PLANES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  fcc_pkg::in_t  item,
    output logic          full,
    output logic          q_push,
    output fcc_pkg::cmd_t q_cmd,
    input  logic          q_full
);

    import fcc_pkg::*;

    logic valid_reg;
    logic valid_next;
    cmd_t cmd_reg;
    cmd_t cmd_dec;
    logic keep;
    logic accept;

    always_comb
    begin
        cmd_dec.kind = CMD_LOAD;
        cmd_dec.idx  = item.plane_index;
        cmd_dec.w0   = item.pos_x;
        cmd_dec.w1   = item.pos_y;
        cmd_dec.w2   = item.pos_z;
        cmd_dec.w3   = COEF_W'({1'b0, item.radius});
        keep         = 1'b0;
        case (item.operation)
            OP_LOAD:
            begin
                keep       = (32'(item.plane_index) < NUM_PLANES);
                cmd_dec.w0 = item.coeff_a;
                cmd_dec.w1 = item.coeff_b;
                cmd_dec.w2 = item.coeff_c;
                cmd_dec.w3 = item.coeff_d;
            end
            OP_POINT:
            begin
                keep         = 1'b1;
                cmd_dec.kind = CMD_POINT;
            end
            OP_SPHERE:
            begin
                keep         = 1'b1;
                cmd_dec.kind = CMD_SPHERE;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign full   = valid_reg && q_full;
    assign accept = push && !full;
    assign q_push = valid_reg && !q_full;
    assign q_cmd  = cmd_reg;

    always_comb
    begin
        valid_next = valid_reg && q_full;
        if (accept)
        begin
            valid_next = keep;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && keep)
        begin
            cmd_reg <= cmd_dec;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/fcc_back.sv
// Back end: plane store, eye registers and the sequenced plane-test datapath.
// Depends on fcc_pkg and the assertion macro header.
`default_nettype none
`include "frustum_cull_classifier_top_macros.svh"

module fcc_back #(
    parameter int NUM_PLANES = fcc_pkg::NUM_PLANES_DEF,
    parameter int FRAC_BITS  = fcc_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [fcc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [fcc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           cmd_valid,
    input  fcc_pkg::cmd_t                  cmd,
    output logic                           cmd_pop,
    input  logic                           res_full,
    output logic                           res_push,
    output fcc_pkg::res_t                  res
);

    import fcc_pkg::*;

    localparam int PW = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EYE_DIFF,
        S_EYE_MUL,
        S_EYE_SUM,
        S_EYE_CMP,
        S_MUL,
        S_SUM,
        S_CMP,
        S_OUT
    } state_t;

    state_t                   state_reg;
    logic [IDX_W-1:0]         cnt_reg;
    cmd_kind_t                kind_reg;
    logic                     inter_reg;
    res_t                     res_reg;

    logic signed [COEF_W-1:0] plane_a_reg [NUM_PLANES];
    logic signed [COEF_W-1:0] plane_b_reg [NUM_PLANES];
    logic signed [COEF_W-1:0] plane_c_reg [NUM_PLANES];
    logic signed [COEF_W-1:0] plane_d_reg [NUM_PLANES];
    logic signed [COEF_W-1:0] eye_reg [3];

    logic signed [COEF_W-1:0] w_reg [LANES];
    logic signed [MUL_W-1:0]  diff_reg [LANES];
    logic signed [PROD_W-1:0] prod_reg [LANES];
    logic signed [DIST_W-1:0] dterm_reg;
    logic signed [DIST_W-1:0] acc_reg;

    logic signed [MUL_W-1:0]  op_a [LANES];
    logic signed [MUL_W-1:0]  op_b [LANES];
    logic signed [PROD_W-1:0] prod [LANES];
    logic [PW-1:0]            sel;
    logic signed [DIST_W-1:0] rs;
    logic signed [DIST_W-1:0] dist_lo;
    logic signed [DIST_W-1:0] dist_hi;
    logic                     cull_hit;
    logic                     inter_hit;
    logic                     last_plane;
    logic                     load_wr;

    assign cmd_pop  = (state_reg == S_IDLE) && cmd_valid;
    assign load_wr  = cmd_pop && (cmd.kind == CMD_LOAD);
    assign res_push = (state_reg == S_OUT) && !res_full;
    assign res      = res_reg;
    assign sel      = cnt_reg[PW-1:0];

    // Shared multiplier lanes: eye distance squares and r*r, or one plane's products.
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            op_a[k] = diff_reg[k];
            op_b[k] = diff_reg[k];
        end
        if (state_reg == S_MUL)
        begin
            op_a[0] = MUL_W'(plane_a_reg[sel]);
            op_a[1] = MUL_W'(plane_b_reg[sel]);
            op_a[2] = MUL_W'(plane_c_reg[sel]);
            op_b[0] = MUL_W'(w_reg[0]);
            op_b[1] = MUL_W'(w_reg[1]);
            op_b[2] = MUL_W'(w_reg[2]);
        end
        for (int k = 0; k < LANES; k++)
        begin
            prod[k] = op_a[k] * op_b[k];
        end
    end

    always_comb
    begin
        rs         = DIST_W'(w_reg[3]) <<< FRAC_BITS;
        dist_lo    = acc_reg + rs;
        dist_hi    = acc_reg - rs;
        last_plane = (32'(cnt_reg) == NUM_PLANES - 1);
        if (kind_reg == CMD_SPHERE)
        begin
            cull_hit  = dist_lo[DIST_W-1];
            inter_hit = dist_hi[DIST_W-1] || (dist_hi == '0);
        end
        else
        begin
            cull_hit  = acc_reg[DIST_W-1];
            inter_hit = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            kind_reg  <= CMD_LOAD;
            inter_reg <= 1'b0;
            res_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cnt_reg   <= '0;
                        kind_reg  <= cmd.kind;
                        inter_reg <= 1'b0;
                        case (cmd.kind)
                            CMD_POINT:  state_reg <= S_MUL;
                            CMD_SPHERE: state_reg <= S_EYE_DIFF;
                            default:    state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_EYE_DIFF: state_reg <= S_EYE_MUL;
                S_EYE_MUL:  state_reg <= S_EYE_SUM;
                S_EYE_SUM:  state_reg <= S_EYE_CMP;
                S_EYE_CMP:
                begin
                    if (acc_reg < DIST_W'(prod_reg[3]))
                    begin
                        res_reg   <= '{VERDICT_INSIDE, '0, 1'b0};
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: state_reg <= S_SUM;
                S_SUM: state_reg <= S_CMP;
                S_CMP:
                begin
                    inter_reg <= inter_reg || inter_hit;
                    if (cull_hit)
                    begin
                        res_reg   <= '{VERDICT_OUTSIDE, cnt_reg, 1'b1};
                        state_reg <= S_OUT;
                    end
                    else if (last_plane)
                    begin
                        res_reg   <= '{(inter_reg || inter_hit) ? VERDICT_INTERSECT
                                                                : VERDICT_INSIDE,
                                       '0, 1'b0};
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        cnt_reg   <= cnt_reg + 1'b1;
                        state_reg <= S_MUL;
                    end
                end
                S_OUT:
                begin
                    if (!res_full)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PLANES; i++)
            begin
                plane_a_reg[i] <= '0;
                plane_b_reg[i] <= '0;
                plane_c_reg[i] <= '0;
                plane_d_reg[i] <= '0;
            end
        end
        else if (load_wr)
        begin
            plane_a_reg[cmd.idx[PW-1:0]] <= cmd.w0;
            plane_b_reg[cmd.idx[PW-1:0]] <= cmd.w1;
            plane_c_reg[cmd.idx[PW-1:0]] <= cmd.w2;
            plane_d_reg[cmd.idx[PW-1:0]] <= cmd.w3;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                eye_reg[i] <= '0;
            end
        end
        else if (cfg_write)
        begin
            case (cfg_addr)
                REG_EYE_X: eye_reg[0] <= cfg_wdata;
                REG_EYE_Y: eye_reg[1] <= cfg_wdata;
                REG_EYE_Z: eye_reg[2] <= cfg_wdata;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            w_reg[0] <= cmd.w0;
            w_reg[1] <= cmd.w1;
            w_reg[2] <= cmd.w2;
            w_reg[3] <= cmd.w3;
        end
        if (state_reg == S_EYE_DIFF)
        begin
            for (int k = 0; k < 3; k++)
            begin
                diff_reg[k] <= MUL_W'(w_reg[k]) - MUL_W'(eye_reg[k]);
            end
            diff_reg[3] <= MUL_W'(w_reg[3]);
        end
        if ((state_reg == S_EYE_MUL) || (state_reg == S_MUL))
        begin
            for (int k = 0; k < LANES; k++)
            begin
                prod_reg[k] <= prod[k];
            end
            dterm_reg <= DIST_W'(plane_d_reg[sel]) <<< FRAC_BITS;
        end
        if (state_reg == S_EYE_SUM)
        begin
            acc_reg <= DIST_W'(prod_reg[0]) + DIST_W'(prod_reg[1]) + DIST_W'(prod_reg[2]);
        end
        if (state_reg == S_SUM)
        begin
            acc_reg <= DIST_W'(prod_reg[0]) + DIST_W'(prod_reg[1])
                     + DIST_W'(prod_reg[2]) + dterm_reg;
        end
    end

    `FCC_ASSERT_NOW(a_culled_outside, res_push && res.culled, res.verdict == VERDICT_OUTSIDE, "culled result not outside")
    `FCC_ASSERT_NOW(a_plane_zero, res_push && !res.culled, res.culling_plane == '0, "plane set on uncull")
    `FCC_ASSERT_NEXT(a_test_starts, cmd_pop && (cmd.kind != CMD_LOAD), state_reg != S_IDLE, "test not started")
    `FCC_ASSERT_NOW(a_cnt_range, state_reg != S_IDLE, 32'(cnt_reg) < NUM_PLANES, "plane counter out of range")
    `FCC_ASSERT_NEXT(a_res_hold, (state_reg == S_OUT) && res_full, (state_reg == S_OUT) && $stable(res_reg), "result dropped while stalled")

endmodule

`default_nettype wire

>>> dv/frustum_cull_classifier_checker.sv
// Checker for the frustum cull classifier: tracks plane loads and eye writes,
// predicts the verdict of each point and sphere transaction, compares results in order.
// Depends on fcc_pkg.
module frustum_cull_classifier_checker
    import fcc_pkg::*;
#(
    parameter int NUM_PLANES = NUM_PLANES_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic                  full,
    input  in_t                   item,
    input  logic                  empty,
    input  logic                  pop,
    input  res_t                  result,
    input  logic                  cfg_write,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    mismatches,
    output int                    outstanding,
    output int                    checked
);

    localparam int ACC_W = 68;

    logic signed [COEF_W-1:0] plane_a [NUM_PLANES];
    logic signed [COEF_W-1:0] plane_b [NUM_PLANES];
    logic signed [COEF_W-1:0] plane_c [NUM_PLANES];
    logic signed [COEF_W-1:0] plane_d [NUM_PLANES];
    logic signed [COEF_W-1:0] eye_x;
    logic signed [COEF_W-1:0] eye_y;
    logic signed [COEF_W-1:0] eye_z;

    res_t pending_verdicts [$];
    int   error_total = 0;
    int   result_total = 0;

    function automatic logic signed [ACC_W-1:0] plane_distance(input int p, input in_t t);
        logic signed [ACC_W-1:0] a;
        logic signed [ACC_W-1:0] b;
        logic signed [ACC_W-1:0] c;
        logic signed [ACC_W-1:0] d;
        a = ACC_W'(plane_a[p]);
        b = ACC_W'(plane_b[p]);
        c = ACC_W'(plane_c[p]);
        d = ACC_W'(plane_d[p]);
        return a * ACC_W'(t.pos_x) + b * ACC_W'(t.pos_y) + c * ACC_W'(t.pos_z)
               + (d <<< FRAC_BITS);
    endfunction

    function automatic logic eye_within(input in_t t);
        logic signed [ACC_W-1:0] dx;
        logic signed [ACC_W-1:0] dy;
        logic signed [ACC_W-1:0] dz;
        logic signed [ACC_W-1:0] r;
        dx = ACC_W'(t.pos_x) - ACC_W'(eye_x);
        dy = ACC_W'(t.pos_y) - ACC_W'(eye_y);
        dz = ACC_W'(t.pos_z) - ACC_W'(eye_z);
        r  = ACC_W'(t.radius);
        return (dx * dx + dy * dy + dz * dz) < (r * r);
    endfunction

    function automatic res_t classify(input in_t t);
        res_t                    v;
        logic signed [ACC_W-1:0] gap;
        logic signed [ACC_W-1:0] reach;
        logic                    grazes;
        v = '0;
        v.verdict = VERDICT_INSIDE;
        reach = ACC_W'(t.radius);
        reach = reach <<< FRAC_BITS;
        grazes = 1'b0;
        if (t.operation == OP_POINT) begin
            for (int p = 0; p < NUM_PLANES; p++) begin
                if (!v.culled && plane_distance(p, t) < 0) begin
                    v.verdict       = VERDICT_OUTSIDE;
                    v.culling_plane = IDX_W'(p);
                    v.culled        = 1'b1;
                end
            end
        end else if (!eye_within(t)) begin
            for (int p = 0; p < NUM_PLANES; p++) begin
                gap = plane_distance(p, t);
                if (!v.culled) begin
                    if (gap + reach < 0) begin
                        v.verdict       = VERDICT_OUTSIDE;
                        v.culling_plane = IDX_W'(p);
                        v.culled        = 1'b1;
                    end else if (gap - reach <= 0) begin
                        grazes = 1'b1;
                    end
                end
            end
            if (!v.culled && grazes)
                v.verdict = VERDICT_INTERSECT;
        end
        return v;
    endfunction

    always @(posedge clk) begin
        res_t want;
        if (!rst_n) begin
            for (int p = 0; p < NUM_PLANES; p++) begin
                plane_a[p] = '0;
                plane_b[p] = '0;
                plane_c[p] = '0;
                plane_d[p] = '0;
            end
            eye_x = '0;
            eye_y = '0;
            eye_z = '0;
            pending_verdicts.delete();
        end else begin
            if (cfg_write) begin
                case (cfg_addr)
                    REG_EYE_X: eye_x = cfg_wdata;
                    REG_EYE_Y: eye_y = cfg_wdata;
                    REG_EYE_Z: eye_z = cfg_wdata;
                    default: ;
                endcase
            end
            if (push && !full) begin
                case (item.operation)
                    OP_LOAD: begin
                        if (item.plane_index < NUM_PLANES) begin
                            plane_a[item.plane_index] = item.coeff_a;
                            plane_b[item.plane_index] = item.coeff_b;
                            plane_c[item.plane_index] = item.coeff_c;
                            plane_d[item.plane_index] = item.coeff_d;
                        end
                    end
                    OP_POINT, OP_SPHERE: pending_verdicts.push_back(classify(item));
                    default: ;
                endcase
            end
            if (pop && !empty) begin
                result_total++;
                if (pending_verdicts.size() == 0) begin
                    $error("unexpected result transaction: verdict %0d, culling_plane %0d",
                           result.verdict, result.culling_plane);
                    error_total++;
                end else begin
                    want = pending_verdicts.pop_front();
                    if (result.verdict !== want.verdict) begin
                        $error("verdict: expected %0d, actual %0d", want.verdict, result.verdict);
                        error_total++;
                    end
                    if (result.culling_plane !== want.culling_plane) begin
                        $error("culling_plane: expected %0d, actual %0d",
                               want.culling_plane, result.culling_plane);
                        error_total++;
                    end
                    if (result.culled !== want.culled) begin
                        $error("culled: expected %0d, actual %0d", want.culled, result.culled);
                        error_total++;
                    end
                end
            end
        end
        mismatches  <= error_total;
        outstanding <= pending_verdicts.size();
        checked     <= result_total;
    end

endmodule

>>> dv/frustum_cull_classifier_top_tb.sv
// Testbench top for frustum_cull_classifier_top: clock, reset, eye register writes,
// bursty transaction stimulus, stalling result sink, watchdog and final verdict.
// Depends on fcc_pkg, the block RTL and frustum_cull_classifier_checker.
module frustum_cull_classifier_top_tb;
    import fcc_pkg::*;

    localparam logic [OP_W-1:0]          OP_RESERVED    = 2'd3;
    localparam logic signed [COEF_W-1:0] ONE            = 32'sd65536;
    localparam logic signed [COEF_W-1:0] MAX_Q          = 32'sh7fffffff;
    localparam logic signed [COEF_W-1:0] MIN_Q          = 32'sh80000000;
    localparam logic [RADIUS_W-1:0]      MAX_R          = 31'h7fffffff;
    localparam logic [RADIUS_W-1:0]      R_ONE          = 31'd65536;
    localparam int                       PHASES         = 12;
    localparam int                       PHASE_ITEMS    = 106;
    localparam int                       SETTLE_CYCLES  = 64;
    localparam int                       WATCHDOG_LIMIT = 4000;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  push      = 1'b0;
    logic                  pop       = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    in_t                   item      = '0;
    logic                  full;
    logic                  empty;
    res_t                  result;

    int mismatches;
    int outstanding;
    int checked;
    int sent = 0;
    int eye_settings = 0;
    int stall_cycles = 0;
    int sink_left = 0;
    int sink_mode = 0;
    logic signed [COEF_W-1:0] eye_now [3] = '{0, 0, 0};

    frustum_cull_classifier_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    frustum_cull_classifier_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .item        (item),
        .empty       (empty),
        .pop         (pop),
        .result      (result),
        .cfg_write   (cfg_write),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .checked     (checked)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic logic signed [COEF_W-1:0] spread(input int unsigned span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    function automatic logic signed [COEF_W-1:0] rand_coeff(input int unsigned span);
        return ($urandom_range(0, 3) == 0) ? $urandom() : spread(span);
    endfunction

    function automatic in_t random_bits();
        in_t t;
        t.operation   = OP_W'($urandom());
        t.plane_index = IDX_W'($urandom());
        t.coeff_a     = $urandom();
        t.coeff_b     = $urandom();
        t.coeff_c     = $urandom();
        t.coeff_d     = $urandom();
        t.pos_x       = $urandom();
        t.pos_y       = $urandom();
        t.pos_z       = $urandom();
        t.radius      = RADIUS_W'($urandom());
        return t;
    endfunction

    function automatic in_t load_item(input logic [IDX_W-1:0] idx,
                                      input logic signed [COEF_W-1:0] a, b, c, d);
        in_t t;
        t = random_bits();
        t.operation   = OP_LOAD;
        t.plane_index = idx;
        t.coeff_a     = a;
        t.coeff_b     = b;
        t.coeff_c     = c;
        t.coeff_d     = d;
        return t;
    endfunction

    function automatic in_t probe_item(input logic [OP_W-1:0] op,
                                       input logic signed [COEF_W-1:0] x, y, z,
                                       input logic [RADIUS_W-1:0] r);
        in_t t;
        t = random_bits();
        t.operation = op;
        t.pos_x     = x;
        t.pos_y     = y;
        t.pos_z     = z;
        t.radius    = r;
        return t;
    endfunction

    function automatic in_t random_item();
        in_t         t;
        int unsigned pick;
        t = random_bits();
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            t = load_item(IDX_W'($urandom_range(0, 7)), rand_coeff(ONE), rand_coeff(ONE),
                          rand_coeff(ONE), rand_coeff(64 * ONE));
        end else if (pick < 11) begin
            t.operation = OP_RESERVED;
        end else begin
            t = probe_item((pick < 55) ? OP_POINT : OP_SPHERE, rand_coeff(80 * ONE),
                           rand_coeff(80 * ONE), rand_coeff(80 * ONE), '0);
            case ($urandom_range(0, 7))
                0:       t.radius = RADIUS_W'($urandom());
                1:       t.radius = '0;
                default: t.radius = RADIUS_W'($urandom_range(0, 16 * ONE));
            endcase
            // sphere around the eye
            if (t.operation == OP_SPHERE && $urandom_range(0, 7) == 0) begin
                t.pos_x  = eye_now[0] + spread(4 * ONE);
                t.pos_y  = eye_now[1] + spread(4 * ONE);
                t.pos_z  = eye_now[2] + spread(4 * ONE);
                t.radius = RADIUS_W'($urandom_range(0, 8 * ONE));
            end
        end
        return t;
    endfunction

    task automatic send_item(input in_t t);
        push <= 1'b1;
        item <= t;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sent++;
    endtask

    task automatic pause(input int cycles);
        if (cycles > 0)
        begin
            push <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_eye(input logic signed [COEF_W-1:0] x, y, z);
        logic [CFG_ADDR_W-1:0]    regs [3];
        logic signed [COEF_W-1:0] vals [3];
        regs = '{REG_EYE_X, REG_EYE_Y, REG_EYE_Z};
        vals = '{x, y, z};
        for (int i = 0; i < 3; i++)
        begin
            cfg_write  <= 1'b1;
            cfg_addr   <= regs[i];
            cfg_wdata  <= vals[i];
            eye_now[i] = vals[i];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        eye_settings++;
    endtask

    // result sink: picks a new random stall pattern each time its countdown runs out
    always @(posedge clk)
    begin
        if (sink_left == 0)
        begin
            sink_mode <= $urandom_range(0, 3);
            sink_left <= $urandom_range(20, 150);
        end
        else
            sink_left <= sink_left - 1;
        case (sink_mode)
            0:       pop <= 1'b1;
            1:       pop <= ($urandom_range(0, 3) != 0);
            2:       pop <= ($urandom_range(0, 4) == 0);
            default: pop <= ((sink_left % 32) < 4);
        endcase
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == WATCHDOG_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int burst_left;
        burst_left = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // planes still at reset: zero distance everywhere
        send_item(probe_item(OP_POINT, 0, 0, 0, '0));
        send_item(probe_item(OP_SPHERE, 0, 0, 0, '0));
        send_item(probe_item(OP_SPHERE, 5 * ONE, -3 * ONE, 0, MAX_R));
        send_item(probe_item(OP_RESERVED, ONE, ONE, ONE, R_ONE));
        send_item(load_item(3'd6, ONE, ONE, ONE, ONE));
        send_item(load_item(3'd7, MIN_Q, MIN_Q, MIN_Q, MIN_Q));

        // axis-aligned box of half-width 10
        send_item(load_item(3'd0, 0, 0, ONE, 10 * ONE));
        send_item(load_item(3'd1, 0, 0, -ONE, 10 * ONE));
        send_item(load_item(3'd2, ONE, 0, 0, 10 * ONE));
        send_item(load_item(3'd3, -ONE, 0, 0, 10 * ONE));
        send_item(load_item(3'd4, 0, -ONE, 0, 10 * ONE));
        send_item(load_item(3'd5, 0, ONE, 0, 10 * ONE));
        send_item(probe_item(OP_POINT, 0, 0, 0, '0));
        send_item(probe_item(OP_POINT, 0, 0, -20 * ONE, '0));
        send_item(probe_item(OP_POINT, -20 * ONE, 0, 0, '0));
        send_item(probe_item(OP_POINT, 0, 0, -10 * ONE, '0));
        send_item(probe_item(OP_POINT, 20 * ONE, 20 * ONE, 20 * ONE, '0));
        send_item(probe_item(OP_SPHERE, 0, 0, -12 * ONE, R_ONE));
        send_item(probe_item(OP_SPHERE, 0, 0, -11 * ONE, R_ONE));
        send_item(probe_item(OP_SPHERE, 5 * ONE, 0, 0, R_ONE));
        send_item(probe_item(OP_SPHERE, 0, 0, -30 * ONE, RADIUS_W'(40 * ONE)));

        send_item(load_item(3'd3, MIN_Q, MAX_Q, MIN_Q, MAX_Q));
        send_item(probe_item(OP_POINT, MAX_Q, MIN_Q, MAX_Q, '0));
        send_item(probe_item(OP_SPHERE, MIN_Q, MIN_Q, MIN_Q, MAX_R));

        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain();
            case (phase)
                0:       set_eye(MAX_Q, MAX_Q, MAX_Q);
                1:       set_eye(MIN_Q, MIN_Q, MIN_Q);
                2:       set_eye(MAX_Q, MIN_Q, 0);
                default: set_eye(rand_coeff(64 * ONE), rand_coeff(64 * ONE),
                                 rand_coeff(64 * ONE));
            endcase
            for (int p = 0; p < NUM_PLANES_DEF; p++)
            begin
                if (phase % 4 == 3)
                    send_item(load_item(IDX_W'(p), rand_coeff(ONE), rand_coeff(ONE),
                                        rand_coeff(ONE), rand_coeff(48 * ONE)));
                else
                    send_item(load_item(IDX_W'(p), spread(ONE), spread(ONE), spread(ONE),
                                        spread(48 * ONE)));
            end
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (burst_left == 0)
                begin
                    pause(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
                    burst_left = $urandom_range(1, 40);
                end
                send_item(random_item());
                burst_left--;
            end
        end

        drain();
        $display("Sent %0d transactions across %0d eye settings; %0d results checked.",
                 sent, eye_settings, checked);
        $display("Covered point, sphere, load and unused codes, box and random planes.");
        if (mismatches == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
